>>> sv/bm25p_pkg.sv
// shared constants, types and helpers of the bm25 posting score accumulator
package bm25p_pkg;

   localparam int DOC_COUNT = 65536;
   localparam int ADDR_W = (DOC_COUNT > 1) ? $clog2(DOC_COUNT) : 1;

   localparam int MODE_W = 2;
   localparam int ID_W = 16;
   localparam int TF_W = 16;
   localparam int DL_W = 16;
   localparam int SCORE_W = 48;
   localparam int Q24_W = 24;
   localparam int RATIO_W = 32;
   localparam int K_W = 16;
   localparam int B_W = 16;
   localparam int AVG_W = 24;
   localparam int DELTA_W = 16;
   localparam int WT_W = 24;
   localparam int BN_W = 17;
   localparam int CONTRIB_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int INFLIGHT_W = 8;

   // divider: dividend, divisor and quotient widths, used by both divider instances
   localparam int DIV_N_W = 53;
   localparam int DIV_D_W = 33;
   localparam int DIV_Q_W = 32;
   localparam int DIV_CMP_W = DIV_D_W + DIV_Q_W;

   localparam logic [MODE_W-1:0] MODE_ACC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ_CLR = 2'd2;

   localparam logic [1:0] VAR_OKAPI = 2'd0;
   localparam logic [1:0] VAR_PLUS = 2'd1;
   localparam logic [1:0] VAR_L = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_VARIANT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_K1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AVG = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DELTA = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT = 3'd5;

   localparam logic [B_W-1:0] B_ONE = 16'd32768;
   localparam logic [BN_W-1:0] K_ONE = 17'd4096;
   localparam logic [Q24_W-1:0] Q24_MAX = 24'hFFFFFF;
   localparam logic [RATIO_W-1:0] RATIO_RESET = 32'd125829;
   localparam logic [K_W-1:0] K1_RESET = 16'd4915;
   localparam logic [B_W-1:0] B_RESET = 16'd24576;
   localparam logic [AVG_W-1:0] AVG_RESET = 24'd25600;
   localparam logic [DELTA_W-1:0] DELTA_RESET = 16'd4096;
   localparam logic [WT_W-1:0] WEIGHT_RESET = 24'd65536;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic [1:0] variant;
      logic [K_W-1:0] k1;
      logic [BN_W-1:0] bn;
      logic [DELTA_W-1:0] delta;
      logic signed [WT_W-1:0] weight;
      logic [RATIO_W-1:0] ratio;
      logic busy;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0] id;
      logic [TF_W-1:0] tf;
      logic [DL_W-1:0] dl;
   } in_type;

   typedef struct packed {
      logic valid;
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0] id;
      logic [TF_W-1:0] tf;
      logic [Q24_W-1:0] norm;
   } side_type;

   typedef struct packed {
      logic valid;
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0] id;
      logic signed [CONTRIB_W-1:0] contrib;
   } mem_item_type;

   function automatic logic doc_in_range(input logic [ID_W-1:0] id);
      return 32'(id) < 32'(DOC_COUNT);
   endfunction

endpackage

>>> sv/bm25p_if.sv
// handshake channels of the accumulator: postings in, scores out, register writes
interface bm25p_req_if import bm25p_pkg::*;;
   logic valid;
   logic ready;
   logic [MODE_W-1:0] mode;
   logic [ID_W-1:0] doc_id;
   logic [TF_W-1:0] term_freq;
   logic [DL_W-1:0] doc_length;
   modport source(output valid, mode, doc_id, term_freq, doc_length, input ready);
   modport sink(input valid, mode, doc_id, term_freq, doc_length, output ready);
endinterface

interface bm25p_rsp_if import bm25p_pkg::*;;
   logic valid;
   logic ready;
   logic [ID_W-1:0] doc_index;
   logic [SCORE_W-1:0] score;
   modport source(output valid, doc_index, score, input ready);
   modport sink(input valid, doc_index, score, output ready);
endinterface

interface bm25p_csr_if import bm25p_pkg::*;;
   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0] wr_data;
   modport source(output valid, reg_index, wr_data, input ready);
   modport sink(input valid, reg_index, wr_data, output ready);
endinterface

>>> sv/bm25p_ram.sv
// generic single write, single read port ram with registered read
module bm25p_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536,
   localparam int RAM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [RAM_AW-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [RAM_AW-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/bm25p_csr.sv
// register file and iterative b / avgdl ratio divider
module bm25p_csr import bm25p_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bm25p_csr_if.sink   csr_ch,
   input  logic        pipe_empty,
   output cfg_type     cfg
);
   localparam int RDVD_W = B_W + 17;
   localparam int RCNT_W = 6;

   logic [1:0] variant_ff;
   logic [K_W-1:0] k1_ff;
   logic [B_W-1:0] b_ff;
   logic [AVG_W-1:0] avg_ff;
   logic [DELTA_W-1:0] delta_ff;
   logic [WT_W-1:0] weight_ff;
   logic [RATIO_W-1:0] ratio_ff;
   logic busy_ff, load_ff;
   logic [RCNT_W-1:0] cnt_ff;
   logic [RDVD_W-1:0] dvd_ff;
   logic [RDVD_W-1:0] quo_ff;
   logic [AVG_W-1:0] rem_ff;

   logic [B_W-1:0] b_clamp;
   logic [AVG_W-1:0] avg_eff;
   logic [AVG_W:0] rem_sh;
   logic rem_ge;
   logic wr_acc;

   assign b_clamp = (b_ff > B_ONE) ? B_ONE : b_ff;
   assign avg_eff = (avg_ff == '0) ? AVG_W'(1) : avg_ff;
   assign rem_sh = {rem_ff, dvd_ff[RDVD_W-1]};
   assign rem_ge = rem_sh >= {1'b0, avg_eff};
   assign wr_acc = csr_ch.valid && csr_ch.ready;
   assign csr_ch.ready = !busy_ff && pipe_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= VAR_OKAPI;
         k1_ff <= K1_RESET;
         b_ff <= B_RESET;
         avg_ff <= AVG_RESET;
         delta_ff <= DELTA_RESET;
         weight_ff <= WEIGHT_RESET;
         ratio_ff <= RATIO_RESET;
         busy_ff <= 1'b0;
         load_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (wr_acc) begin
            case (csr_ch.reg_index)
               REG_VARIANT: variant_ff <= csr_ch.wr_data[1:0];
               REG_K1: k1_ff <= csr_ch.wr_data[K_W-1:0];
               REG_B: begin
                  b_ff <= csr_ch.wr_data[B_W-1:0];
                  busy_ff <= 1'b1;
                  load_ff <= 1'b1;
               end
               REG_AVG: begin
                  avg_ff <= csr_ch.wr_data[AVG_W-1:0];
                  busy_ff <= 1'b1;
                  load_ff <= 1'b1;
               end
               REG_DELTA: delta_ff <= csr_ch.wr_data[DELTA_W-1:0];
               REG_WEIGHT: weight_ff <= csr_ch.wr_data[WT_W-1:0];
               default: ;
            endcase
         end else if (load_ff) begin
            load_ff <= 1'b0;
            dvd_ff <= {b_clamp, 17'b0};
            rem_ff <= '0;
            cnt_ff <= RCNT_W'(RDVD_W);
         end else if (busy_ff && cnt_ff != '0) begin
            // one quotient bit per cycle, msb first
            rem_ff <= rem_ge ? AVG_W'(rem_sh - {1'b0, avg_eff}) : rem_sh[AVG_W-1:0];
            quo_ff <= {quo_ff[RDVD_W-2:0], rem_ge};
            dvd_ff <= {dvd_ff[RDVD_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - RCNT_W'(1);
         end else if (busy_ff) begin
            ratio_ff <= (|quo_ff[RDVD_W-1:RATIO_W]) ? '1 : quo_ff[RATIO_W-1:0];
            busy_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      cfg.variant = variant_ff;
      cfg.k1 = k1_ff;
      cfg.bn = BN_W'((BN_W'(B_ONE) - BN_W'(b_clamp)) << 1);
      cfg.delta = delta_ff;
      cfg.weight = $signed(weight_ff);
      cfg.ratio = ratio_ff;
      cfg.busy = busy_ff;
   end
endmodule

>>> sv/bm25p_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module bm25p_div import bm25p_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic [DIV_N_W-1:0] dvd_in,
   input  logic [DIV_D_W-1:0] dvs_in,
   input  side_type           side_in,
   output logic [DIV_Q_W-1:0] quo,
   output logic               ovf,
   output logic               dvs_zero,
   output side_type           side_out
);
   logic [DIV_N_W-1:0] rem_ff [DIV_Q_W+1];
   logic [DIV_D_W-1:0] dvs_ff [DIV_Q_W+1];
   logic [DIV_Q_W-1:0] q_ff [DIV_Q_W+1];
   logic ovf_ff [DIV_Q_W+1];
   side_type side_ff [DIV_Q_W+1];

   // quotient would not fit when dividend >= divisor * 2^32
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0] <= '0;
      end else if (adv) begin
         side_ff[0] <= side_in;
         rem_ff[0] <= dvd_in;
         dvs_ff[0] <= dvs_in;
         q_ff[0] <= '0;
         ovf_ff[0] <= DIV_CMP_W'(dvd_in) >= {dvs_in, DIV_Q_W'(0)};
      end
   end

   for (genvar k = 1; k <= DIV_Q_W; k++) begin : g_stage
      localparam int BIT = DIV_Q_W - k;
      logic [DIV_CMP_W-1:0] trial;
      logic take;
      assign trial = DIV_CMP_W'(dvs_ff[k-1]) << BIT;
      assign take = DIV_CMP_W'(rem_ff[k-1]) >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k] <= '0;
         end else if (adv) begin
            side_ff[k] <= side_ff[k-1];
            rem_ff[k] <= take ? DIV_N_W'(DIV_CMP_W'(rem_ff[k-1]) - trial) : rem_ff[k-1];
            dvs_ff[k] <= dvs_ff[k-1];
            q_ff[k] <= q_ff[k-1] | (DIV_Q_W'(take) << BIT);
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo = q_ff[DIV_Q_W];
   assign ovf = ovf_ff[DIV_Q_W];
   assign dvs_zero = dvs_ff[DIV_Q_W] == '0;
   assign side_out = side_ff[DIV_Q_W];
endmodule

>>> sv/bm25p_score.sv
// score memory stage: read, forward, saturating add, write back, result register
module bm25p_score import bm25p_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  mem_item_type  m0,
   output logic          adv,
   output logic          clearing,
   output logic          retire,
   bm25p_rsp_if.source   rsp_ch
);
   mem_item_type m1_ff;
   logic clearing_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic lw_valid_ff;
   logic [ADDR_W-1:0] lw_addr_ff;
   logic [SCORE_W-1:0] lw_data_ff;
   logic rsp_valid_ff;
   logic [ID_W-1:0] rsp_index_ff;
   logic [SCORE_W-1:0] rsp_score_ff;

   logic [SCORE_W-1:0] ram_q, old, sum_sat, wr_val;
   logic [SCORE_W:0] sum;
   logic in_range, fwd, wr_item, has_rsp, is_acc;
   logic [ADDR_W-1:0] m1_addr;
   logic ram_we;
   logic [ADDR_W-1:0] ram_wa;
   logic [SCORE_W-1:0] ram_wd;

   assign m1_addr = ADDR_W'(m1_ff.id);
   assign in_range = doc_in_range(m1_ff.id);
   // the write done in the same cycle as this item's read is not in ram_q yet
   assign fwd = lw_valid_ff && (lw_addr_ff == m1_addr);
   assign old = fwd ? lw_data_ff : ram_q;
   assign sum = (SCORE_W+1)'($signed(old)) + (SCORE_W+1)'(m1_ff.contrib);
   assign sum_sat = (sum[SCORE_W] != sum[SCORE_W-1]) ?
                    (sum[SCORE_W] ? SCORE_MIN : SCORE_MAX) : sum[SCORE_W-1:0];
   assign is_acc = m1_ff.mode == MODE_ACC;
   assign wr_item = m1_ff.valid && in_range && (is_acc || m1_ff.mode == MODE_READ_CLR);
   assign wr_val = is_acc ? sum_sat : '0;
   assign has_rsp = m1_ff.valid && (m1_ff.mode == MODE_READ || m1_ff.mode == MODE_READ_CLR);

   assign adv = !(has_rsp && rsp_valid_ff && !rsp_ch.ready);
   assign retire = adv && m1_ff.valid;
   assign clearing = clearing_ff;

   assign ram_we = clearing_ff || (adv && wr_item);
   assign ram_wa = clearing_ff ? clr_cnt_ff : m1_addr;
   assign ram_wd = clearing_ff ? '0 : wr_val;

   bm25p_ram #(.WIDTH(SCORE_W), .DEPTH(DOC_COUNT)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (adv),
      .rd_addr (ADDR_W'(m0.id)),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff <= '0;
         clearing_ff <= 1'b1;
         clr_cnt_ff <= '0;
         lw_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == ADDR_W'(DOC_COUNT - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (adv) begin
            m1_ff <= m0;
            lw_valid_ff <= wr_item;
            lw_addr_ff <= m1_addr;
            lw_data_ff <= wr_val;
         end
         if (adv && has_rsp) begin
            rsp_valid_ff <= 1'b1;
            rsp_index_ff <= m1_ff.id;
            rsp_score_ff <= in_range ? old : '0;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.doc_index = rsp_index_ff;
   assign rsp_ch.score = rsp_score_ff;
endmodule

>>> sv/bm25_posting_score_accumulator_core.sv
// bm25 posting score accumulator top level: arithmetic pipeline and score memory
//
//  channel  dir  handshake      carries
//  req_ch   in   valid/ready    mode, doc_id, term_freq, doc_length
//  rsp_ch   out  valid/ready    doc_index, score (one per read item)
//  csr_ch   in   valid/ready    reg_index, wr_data
//
// one item per cycle while req_ready is high; a read item's result passes through
// the two 33-stage dividers (an input stage, then one quotient bit per stage).
// after reset the score memory is zeroed by a sweep over all DOC_COUNT entries, req_ready low.
// a write to b or avgdl recomputes the length ratio, req_ready low.
// the whole pipeline holds only while a read result meets a full, stalled output register.
module bm25_posting_score_accumulator_core import bm25p_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bm25p_req_if.sink   req_ch,
   bm25p_rsp_if.source rsp_ch,
   bm25p_csr_if.sink   csr_ch
);
   cfg_type cfg;
   logic adv, clearing, retire, accept, pipe_empty;
   logic [INFLIGHT_W-1:0] inflight_ff, inflight_in;

   in_type s0_ff, s0_in, s1_ff;
   logic [47:0] s1_prod_ff, prod_in;
   side_type s2_ff, s2_in;
   logic [40:0] norm_sum;

   logic [DIV_Q_W-1:0] q1, q2;
   logic ovf1, ovf2, zero1, zero2;
   side_type side3, side6, s4_ff, s5_ff, s7_ff, s8_ff;
   logic [DIV_Q_W-1:0] c_val, mul_a_op, s4_c_ff;
   logic [48:0] prod_a_in, s4_pa_ff;
   logic [39:0] prod_b_in, s4_pb_ff;
   logic [DIV_N_W-1:0] dvd5_in, s5_dvd_ff;
   logic [DIV_D_W-1:0] dvs5_in, s5_dvs_ff;
   logic [Q24_W-1:0] fq, f_in, s7_f_ff;
   logic [Q24_W:0] fd;
   logic signed [47:0] p_in, s8_p_ff;
   mem_item_type m0_ff, m0_in;

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = adv && !clearing && !cfg.busy && !csr_ch.valid;
   assign pipe_empty = inflight_ff == '0;
   assign inflight_in = inflight_ff + INFLIGHT_W'(accept) - INFLIGHT_W'(retire);

   bm25p_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_ch     (csr_ch),
      .pipe_empty (pipe_empty),
      .cfg        (cfg)
   );

   always_comb begin
      s0_in.valid = accept;
      s0_in.mode = req_ch.mode;
      s0_in.id = req_ch.doc_id;
      s0_in.tf = req_ch.term_freq;
      s0_in.dl = req_ch.doc_length;
   end

   assign prod_in = cfg.ratio * s0_ff.dl;
   assign norm_sum = 41'(cfg.bn) + 41'(s1_prod_ff[47:8]);

   always_comb begin
      s2_in.valid = s1_ff.valid;
      s2_in.mode = s1_ff.mode;
      s2_in.id = s1_ff.id;
      s2_in.tf = s1_ff.tf;
      s2_in.norm = (|norm_sum[40:24]) ? Q24_MAX : norm_sum[23:0];
   end

   // c = tf / norm, zero norm lands in the overflow flag
   bm25p_div u_div_c (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .dvd_in   (DIV_N_W'({s2_ff.tf, 32'b0})),
      .dvs_in   (DIV_D_W'(s2_ff.norm)),
      .side_in  (s2_ff),
      .quo      (q1),
      .ovf      (ovf1),
      .dvs_zero (zero1),
      .side_out (side3)
   );

   assign c_val = (ovf1 || zero1) ? '1 : q1;
   assign mul_a_op = (cfg.variant == VAR_L) ? c_val : DIV_Q_W'(side3.tf);
   assign prod_a_in = (BN_W'(cfg.k1) + K_ONE) * mul_a_op;
   assign prod_b_in = cfg.k1 * side3.norm;

   always_comb begin
      if (cfg.variant == VAR_L) begin
         dvd5_in = DIV_N_W'({s4_pa_ff, 4'b0});
         dvs5_in = DIV_D_W'(s4_c_ff) + DIV_D_W'({cfg.k1, 4'b0});
      end else begin
         dvd5_in = DIV_N_W'({s4_pa_ff[32:0], 20'b0});
         dvs5_in = DIV_D_W'({s4_ff.tf, 16'b0}) + DIV_D_W'(s4_pb_ff[39:12]);
      end
   end

   bm25p_div u_div_f (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .dvd_in   (s5_dvd_ff),
      .dvs_in   (s5_dvs_ff),
      .side_in  (s5_ff),
      .quo      (q2),
      .ovf      (ovf2),
      .dvs_zero (zero2),
      .side_out (side6)
   );

   // zero divisor only comes with a zero dividend: factor is zero
   assign fq = zero2 ? '0 : ((ovf2 || |q2[DIV_Q_W-1:Q24_W]) ? Q24_MAX : q2[Q24_W-1:0]);
   assign fd = (Q24_W+1)'(fq) + (Q24_W+1)'({cfg.delta, 4'b0});
   assign f_in = (cfg.variant == VAR_PLUS || cfg.variant == VAR_L) ?
                 (fd[Q24_W] ? Q24_MAX : fd[Q24_W-1:0]) : fq;
   assign p_in = $signed(cfg.weight) * $signed({1'b0, s7_f_ff});

   always_comb begin
      m0_in.valid = s8_ff.valid;
      m0_in.mode = s8_ff.mode;
      m0_in.id = s8_ff.id;
      m0_in.contrib = s8_p_ff[47:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         s0_ff <= '0;
         s1_ff <= '0;
         s2_ff <= '0;
         s4_ff <= '0;
         s5_ff <= '0;
         s7_ff <= '0;
         s8_ff <= '0;
         m0_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
         if (adv) begin
            s0_ff <= s0_in;
            s1_ff <= s0_ff;
            s1_prod_ff <= prod_in;
            s2_ff <= s2_in;
            s4_ff <= side3;
            s4_c_ff <= c_val;
            s4_pa_ff <= prod_a_in;
            s4_pb_ff <= prod_b_in;
            s5_ff <= s4_ff;
            s5_dvd_ff <= dvd5_in;
            s5_dvs_ff <= dvs5_in;
            s7_ff <= side6;
            s7_f_ff <= f_in;
            s8_ff <= s7_ff;
            s8_p_ff <= p_in;
            m0_ff <= m0_in;
         end
      end
   end

   bm25p_score u_score (
      .clock    (clock),
      .reset    (reset),
      .m0       (m0_ff),
      .adv      (adv),
      .clearing (clearing),
      .retire   (retire),
      .rsp_ch   (rsp_ch)
   );
endmodule

>>> sv/bm25p_checker.sv
// port-level checks of the accumulator, bound to the top level
module bm25p_checker import bm25p_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [ID_W-1:0]      rsp_doc_index,
   input logic [SCORE_W-1:0]   rsp_score,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index
);
   // memory sweep follows every reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("item taken before score memory clear");

   // ratio recompute blocks items
   a_ratio_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index == REG_B || csr_index == REG_AVG)) |=> !req_ready)
      else $error("item taken while length ratio is recomputed");

   a_no_cfg_with_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !csr_valid)
      else $error("item taken alongside a register write");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_doc_index) && $stable(rsp_score)))
      else $error("stalled result changed");
endmodule

bind bm25_posting_score_accumulator_core bm25p_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_doc_index (rsp_ch.doc_index),
   .rsp_score     (rsp_ch.score),
   .csr_valid     (csr_ch.valid),
   .csr_ready     (csr_ch.ready),
   .csr_index     (csr_ch.reg_index)
);
